FILE: src/lsfb_pkg.sv
package lsfb_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LED   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  localparam logic [WORD_W-1:0] START_WORD   = 32'h0000_0000;
  localparam logic [WORD_W-1:0] END_WORD     = 32'hFFFF_FFFF;
  localparam logic [7:0]        BRIGHT_FORCE = 8'hE0;

  typedef enum logic [1:0] {
    PH_START,
    PH_LED,
    PH_END
  } lsfb_phase_t;

  // One classified LED frame on its way from the front to the back.
  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic               first;
    logic [COUNT_W-1:0] ends;
  } lsfb_entry_t;

endpackage

FILE: src/led_strip_frame_builder.sv
// LED strip frame builder for a two-wire addressable LED strip.
//
// s_* takes one LED frame per beat. m_* gives the 32-bit words to shift out
// most significant bit first: a start word of zeros before the first LED,
// one LED word per frame with the top three brightness bits set, and after
// the last LED of the strip (n+1)/2 end words of ones. tlast marks the last
// word caused by one input frame; tuser carries the word kind.
// cfg_* writes the strip length, n; 0 counts as 1 and values above MAX_LEDS
// count as MAX_LEDS. The write is always ready.
//
// A frame accepted on s_* passes the queue and the sequencer's current-frame
// registers before its first word appears on m_*. The back end sends one word
// per cycle while m_tready is high; the first and last LED of a strip give
// extra words. A four-entry queue between classifier and word sequencer
// absorbs those bursts; s_tready drops only while it is full. When m_tready is
// low the output beat holds and the queue fills. Reset empties the queue, sets
// n to 1 and starts at the first LED.
module led_strip_frame_builder
  import lsfb_pkg::*;
#(
  parameter int unsigned MAX_LEDS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data,   // led_count
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [31:0]        s_tdata,    // brightness, blue, green, red
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [WORD_W-1:0]  m_tdata,    // wire_word
  output logic [KIND_W-1:0]  m_tuser,    // word_kind
  output logic               m_tlast     // last_of_run
);

  lsfb_entry_t entry;
  lsfb_entry_t head;
  logic        full;
  logic        take;
  logic        head_valid;
  logic        pop;

  assign cfg_ready = 1'b1;
  assign s_tready  = !full;
  assign take      = s_tvalid && s_tready;

  lsfb_front #(
    .MAX_LEDS(MAX_LEDS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .take     (take),
    .frame    (s_tdata),
    .entry    (entry)
  );

  lsfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (entry),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  lsfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: src/lsfb_front.sv
module lsfb_front
  import lsfb_pkg::*;
#(
  parameter int unsigned MAX_LEDS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               take,
  input  logic [31:0]        frame,
  output lsfb_entry_t        entry
);

  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_LEDS);

  logic [COUNT_W-1:0] led_count;
  logic [COUNT_W-1:0] led_position;
  logic [COUNT_W-1:0] led_position_next;
  logic [COUNT_W-1:0] eff_count;
  logic [COUNT_W:0]   pos_inc;
  logic [COUNT_W:0]   ends_sum;
  logic               strip_end;

  always_comb begin
    if (led_count == '0) begin
      eff_count = COUNT_W'(1);
    end else if (led_count > MaxCount) begin
      eff_count = MaxCount;
    end else begin
      eff_count = led_count;
    end
  end

  assign pos_inc   = {1'b0, led_position} + (COUNT_W+1)'(1);
  assign strip_end = pos_inc >= {1'b0, eff_count};
  assign ends_sum  = {1'b0, eff_count} + (COUNT_W+1)'(1);

  assign led_position_next = strip_end ? '0 : pos_inc[COUNT_W-1:0];

  always_comb begin
    entry.word  = {frame[7:0] | BRIGHT_FORCE, frame[15:8], frame[23:16], frame[31:24]};
    entry.first = led_position == '0;
    entry.ends  = strip_end ? ends_sum[COUNT_W:1] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count    <= COUNT_W'(1);
      led_position <= '0;
    end else begin
      if (cfg_valid) begin
        led_count <= cfg_data;
      end
      if (take) begin
        led_position <= led_position_next;
      end
    end
  end

endmodule

FILE: src/lsfb_queue.sv
module lsfb_queue
  import lsfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  lsfb_entry_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output lsfb_entry_t head
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  lsfb_entry_t       mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [PtrW:0]     fill;

  assign full       = fill == (PtrW+1)'(Depth);
  assign head_valid = fill != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PtrW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PtrW+1)'(1);
      end
    end
  end

endmodule

FILE: src/lsfb_back.sv
module lsfb_back
  import lsfb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  lsfb_entry_t       head,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [WORD_W-1:0] m_tdata,
  output logic [KIND_W-1:0] m_tuser,
  output logic              m_tlast
);

  logic               cur_valid;
  logic               cur_valid_next;
  lsfb_phase_t        cur_phase;
  lsfb_phase_t        cur_phase_next;
  logic [WORD_W-1:0]  cur_word;
  logic [COUNT_W-1:0] cur_left;
  logic [COUNT_W-1:0] cur_left_next;

  logic               advance;
  logic               done;
  logic [WORD_W-1:0]  emit_word;
  logic [KIND_W-1:0]  emit_kind;

  // The output register moves whenever it is empty or its beat is taken.
  assign advance = !m_tvalid || m_tready;
  assign pop     = advance && (!cur_valid || done) && head_valid;

  // Output decode of the current phase.
  always_comb begin
    emit_word = START_WORD;
    emit_kind = KIND_START;
    done      = 1'b0;
    unique case (cur_phase)
      PH_START: begin
        emit_word = START_WORD;
        emit_kind = KIND_START;
        done      = 1'b0;
      end
      PH_LED: begin
        emit_word = cur_word;
        emit_kind = KIND_LED;
        done      = cur_left == '0;
      end
      PH_END: begin
        emit_word = END_WORD;
        emit_kind = KIND_END;
        done      = cur_left == COUNT_W'(1);
      end
      default: begin
        emit_word = START_WORD;
        emit_kind = KIND_START;
        done      = 1'b0;
      end
    endcase
  end

  // Next phase, including the load of the next frame from the queue.
  always_comb begin
    cur_valid_next = cur_valid;
    cur_phase_next = cur_phase;
    cur_left_next  = cur_left;
    if (advance) begin
      if (!cur_valid || done) begin
        cur_valid_next = head_valid;
        if (head_valid) begin
          cur_phase_next = head.first ? PH_START : PH_LED;
          cur_left_next  = head.ends;
        end
      end else begin
        unique case (cur_phase)
          PH_START: cur_phase_next = PH_LED;
          PH_LED:   cur_phase_next = PH_END;
          PH_END:   cur_left_next  = cur_left - COUNT_W'(1);
          default:  cur_phase_next = PH_LED;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_phase <= PH_START;
      m_tvalid  <= 1'b0;
    end else begin
      cur_valid <= cur_valid_next;
      cur_phase <= cur_phase_next;
      if (advance) begin
        m_tvalid <= cur_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_left <= cur_left_next;
    if (pop) begin
      cur_word <= head.word;
    end
    if (advance) begin
      m_tdata <= emit_word;
      m_tuser <= emit_kind;
      m_tlast <= cur_valid && done;
    end
  end

endmodule
